>>> rtl/bpeg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpeg_pkg
// Shared types, codes and helpers of the breakpoint envelope gain block.
// ----------------------------------------------------------------------------
package bpeg_pkg;

  // Item modes
  typedef enum logic [1:0] {
    MODE_SET    = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_CLOSE  = 2'd2,
    MODE_APPLY  = 2'd3
  } mode_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DROP = 2'd2
  } status_e;

  // Command beat from the front end to the engine
  typedef struct packed {
    mode_e              mode;
    logic               src_ok;
    logic [3:0]         source;
    logic [30:0]        frame;
    logic [23:0]        level;
    logic [15:0]        sample;
  } cmd_t;

  // Result beat
  typedef struct packed {
    logic [15:0] sample;
    status_e     status;
  } res_t;

  // Engine sequencer states
  typedef enum logic [4:0] {
    E_IDLE, E_DISP, E_LAST_RD, E_LAST_LAT, E_APP_CMP, E_PREV, E_CLOSE, E_DIV,
    E_AP_M1, E_NT, E_W_START, E_W_CHK0, E_W_LOOP, E_W_NXT, E_W_LV, E_W_P1,
    E_W_P2, E_W_P3, E_W_P4, E_M2_LO, E_M2_HI, E_M2_SUM, E_SAT, E_DONE
  } eng_state_e;

  localparam logic [30:0] ENV_END = 31'h7fffffff;
  localparam logic [23:0] UNITY   = 24'h010000;

  function automatic logic [15:0] abs16(input logic [15:0] v);
    abs16 = v[15] ? 16'(-v) : v;
  endfunction

  function automatic logic [23:0] abs24(input logic [23:0] v);
    abs24 = v[23] ? 24'(-v) : v;
  endfunction

  function automatic logic [47:0] abs48(input logic [47:0] v);
    abs48 = v[47] ? 48'(-v) : v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/bpeg_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpeg_fifo
// Two-entry queue used between the front end, engine and result port.
// ----------------------------------------------------------------------------
module bpeg_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] wdata_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic [W-1:0]      rdata_o,
  output logic              empty_o
);

  logic [W-1:0] mem_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q;
  logic         do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= !wptr_q;
      if (do_pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

endmodule
`default_nettype wire

>>> rtl/bpeg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpeg_front
// Accepts input beats, checks the source range and queues commands.
// ----------------------------------------------------------------------------
module bpeg_front #(
  parameter int NUM_SOURCES = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire logic [1:0]    mode_i,
  input  wire logic [3:0]    source_i,
  input  wire logic [30:0]   frame_index_i,
  input  wire logic [23:0]   level_i,
  input  wire logic [15:0]   sample_in_i,
  output logic               cmd_valid_o,
  output bpeg_pkg::cmd_t     cmd_o,
  input  wire logic          cmd_pop_i
);
  import bpeg_pkg::*;

  cmd_t                 cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_raw;
  logic                 q_empty;

  // classify the beat
  always_comb begin
    cmd_in.mode   = mode_e'(mode_i);
    cmd_in.src_ok = (32'(source_i) < NUM_SOURCES);
    cmd_in.source = source_i;
    cmd_in.frame  = frame_index_i;
    cmd_in.level  = level_i;
    cmd_in.sample = sample_in_i;
  end

  bpeg_fifo #(.W($bits(cmd_t))) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_raw),
    .empty_o (q_empty)
  );

  assign cmd_o       = cmd_t'(cmd_raw);
  assign cmd_valid_o = !q_empty;

endmodule
`default_nettype wire

>>> rtl/bpeg_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpeg_div
// Bit-serial slope divider: (dy * 2^24) / dx, truncated, clamped to 48 bits.
// ----------------------------------------------------------------------------
module bpeg_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [24:0] dy_i,
  input  wire logic [31:0] dx_i,
  output logic             done_o,
  output logic [47:0]      quot_o
);

  localparam logic [48:0] LIM = 49'h1 << 47;

  logic [30:0] den_q, rem_q;
  logic [48:0] quo_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q, neg_q;
  logic [31:0] trial;
  logic [24:0] dy_mag;
  logic [31:0] dx_mag;
  logic        ge;

  assign dy_mag = dy_i[24] ? 25'(-dy_i) : dy_i;
  assign dx_mag = dx_i[31] ? 32'(-dx_i) : dx_i;
  assign trial  = {rem_q, quo_q[48]};
  assign ge     = (trial >= {1'b0, den_q});

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= (dx_mag != 32'd0);
        done_q <= (dx_mag == 32'd0);
        cnt_q  <= 6'd48;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring step, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= dx_mag[30:0];
      rem_q <= '0;
      quo_q <= (dx_mag == 32'd0) ? 49'd0 : {dy_mag, 24'd0};
      neg_q <= dy_i[24] ^ dx_i[31];
    end else if (busy_q) begin
      rem_q <= ge ? 31'(trial - {1'b0, den_q}) : trial[30:0];
      quo_q <= {quo_q[47:0], ge};
    end
  end

  // sign and clamp
  always_comb begin
    if (!neg_q) quot_o = (quo_q > LIM - 49'd1) ? 48'h7fff_ffff_ffff : quo_q[47:0];
    else        quot_o = (quo_q > LIM) ? 48'h8000_0000_0000 : 48'(-quo_q);
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

>>> rtl/bpeg_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpeg_engine
// Back end: breakpoint tables, segment walk, interpolation and gain.
// ----------------------------------------------------------------------------
module bpeg_engine #(
  parameter int NUM_SOURCES = 16,
  parameter int MAX_POINTS  = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  bpeg_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  input  wire logic           out_full_i,
  output logic                out_push_o,
  output bpeg_pkg::res_t      out_o
);
  import bpeg_pkg::*;

  localparam int SW    = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int KW    = $clog2(MAX_POINTS);
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int AW    = SW + KW;
  localparam int DEPTH = NUM_SOURCES << KW;
  localparam logic [78:0] SAT62 = 79'h1 << 62;

  eng_state_e state_q, state_d;

  // per-source state
  logic [CW-1:0] cnt_q [NUM_SOURCES];
  logic [KW-1:0] cur_q [NUM_SOURCES];
  logic [23:0]   fac_q [NUM_SOURCES];
  logic          en_q  [NUM_SOURCES];

  // breakpoint memories
  logic [30:0] start_mem [DEPTH];
  logic [23:0] lvl_mem   [DEPTH];
  logic [47:0] slope_mem [DEPTH];
  logic [30:0] rd_start_q;
  logic [23:0] rd_lvl_q;
  logic [47:0] rd_slope_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic        we_start, we_lvl, we_slope;
  logic [30:0] wd_start;
  logic [23:0] wd_lvl;
  logic [47:0] wd_slope;

  // datapath registers
  cmd_t          cmd_q;
  logic [KW-1:0] last_q, tgt_q, w_cur_q;
  logic [30:0]   ls_start_q, x0_q, d_q;
  logic [23:0]   ls_lvl_q, lvl0_q, env_q;
  logic [47:0]   smag_q;
  logic          sneg_q, neg_q;
  logic [54:0]   pp_lo_q, pp_hi_q;
  logic [38:0]   qmag_q;
  logic [39:0]   m1_q;
  logic [43:0]   m2lo_q, m2hi_q;
  logic [31:0]   rmag_q;
  logic [15:0]   res_smp_q;
  status_e       res_st_q;

  // divider
  logic        div_start, div_done;
  logic [24:0] div_dy;
  logic [31:0] div_dx;
  logic [47:0] div_quot;

  // strobes to the per-source state
  logic          src_set, cnt_one, cnt_inc, en_set, cur_wr;
  logic [KW-1:0] cur_wd;

  logic [SW-1:0] s_idx;
  logic [CW-1:0] cnt_s, w_next;
  logic [KW-1:0] cur_s, last_k, start_cur;
  logic [23:0]   fac_s, emag;
  logic          en_s, has_next, found_nxt, found_last, found_go, miss_go;
  eng_state_e    after_last;

  assign s_idx      = SW'(cmd_q.source);
  assign cnt_s      = cnt_q[s_idx];
  assign cur_s      = cur_q[s_idx];
  assign fac_s      = fac_q[s_idx];
  assign en_s       = en_q[s_idx];
  assign last_k     = KW'(cnt_s - CW'(1));
  assign start_cur  = (CW'(cur_s) >= cnt_s) ? '0 : cur_s;
  assign w_next     = CW'(w_cur_q) + CW'(1);
  assign has_next   = (w_next < cnt_s);
  assign found_nxt  = (cmd_q.frame >= x0_q) && (cmd_q.frame < rd_start_q);
  assign found_last = (cmd_q.frame >= x0_q) && (cmd_q.frame < ENV_END);
  assign after_last = (cmd_q.mode == MODE_APPEND) ? E_APP_CMP : E_CLOSE;
  assign emag       = abs24(env_q);

  bpeg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dy_i    (div_dy),
    .dx_i    (div_dx),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= E_IDLE;
    else         state_q <= state_d;
  end

  // next state, memory control and strobes
  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    out_push_o = 1'b0;
    rd_addr   = {s_idx, w_cur_q};
    wr_addr   = {s_idx, last_q};
    we_start  = 1'b0;
    we_lvl    = 1'b0;
    we_slope  = 1'b0;
    wd_start  = '0;
    wd_lvl    = '0;
    wd_slope  = '0;
    div_start = 1'b0;
    div_dy    = '0;
    div_dx    = '0;
    src_set   = 1'b0;
    cnt_one   = 1'b0;
    cnt_inc   = 1'b0;
    en_set    = 1'b0;
    cur_wr    = 1'b0;
    cur_wd    = '0;
    found_go  = 1'b0;
    miss_go   = 1'b0;
    unique case (state_q)
      E_IDLE: begin
        if (cmd_valid_i && !out_full_i) begin
          cmd_pop_o = 1'b1;
          state_d   = E_DISP;
        end
      end
      E_DISP: begin
        if (!cmd_q.src_ok) begin
          state_d = E_DONE;
        end else begin
          unique case (cmd_q.mode)
            MODE_SET: begin
              src_set = 1'b1;
              state_d = E_DONE;
            end
            MODE_APPEND, MODE_CLOSE: state_d = en_s ? E_DONE : E_LAST_RD;
            MODE_APPLY:              state_d = E_AP_M1;
            default:                 state_d = E_DONE;
          endcase
        end
      end
      E_LAST_RD: begin
        if (cnt_s == '0) begin
          // implicit origin entry
          wr_addr  = {s_idx, {KW{1'b0}}};
          we_start = 1'b1;
          we_lvl   = 1'b1;
          we_slope = 1'b1;
          cnt_one  = 1'b1;
          state_d  = after_last;
        end else begin
          rd_addr = {s_idx, last_k};
          state_d = E_LAST_LAT;
        end
      end
      E_LAST_LAT: state_d = after_last;
      E_APP_CMP: begin
        if (cmd_q.frame == ls_start_q) begin
          // repeated frame: replace the level
          we_lvl = 1'b1;
          wd_lvl = cmd_q.level;
          if (cnt_s >= CW'(2)) begin
            rd_addr = {s_idx, last_q - KW'(1)};
            state_d = E_PREV;
          end else begin
            state_d = E_DONE;
          end
        end else if (cnt_s == CW'(MAX_POINTS)) begin
          state_d = E_DONE;
        end else begin
          wr_addr   = {s_idx, last_q + KW'(1)};
          we_start  = 1'b1;
          we_lvl    = 1'b1;
          we_slope  = 1'b1;
          wd_start  = cmd_q.frame;
          wd_lvl    = cmd_q.level;
          cnt_inc   = 1'b1;
          div_start = 1'b1;
          div_dy    = {cmd_q.level[23], cmd_q.level} - {ls_lvl_q[23], ls_lvl_q};
          div_dx    = {1'b0, cmd_q.frame} - {1'b0, ls_start_q};
          state_d   = E_DIV;
        end
      end
      E_PREV: begin
        div_start = 1'b1;
        div_dy    = {cmd_q.level[23], cmd_q.level} - {rd_lvl_q[23], rd_lvl_q};
        div_dx    = {1'b0, cmd_q.frame} - {1'b0, rd_start_q};
        state_d   = E_DIV;
      end
      E_CLOSE: begin
        // tail ramps to zero at the end frame
        div_start = 1'b1;
        div_dy    = 25'd0 - {ls_lvl_q[23], ls_lvl_q};
        div_dx    = {1'b0, ENV_END} - {1'b0, ls_start_q};
        en_set    = 1'b1;
        cur_wr    = 1'b1;
        state_d   = E_DIV;
      end
      E_DIV: begin
        if (div_done) begin
          wr_addr  = {s_idx, tgt_q};
          we_slope = 1'b1;
          wd_slope = div_quot;
          state_d  = E_DONE;
        end
      end
      E_AP_M1: state_d = en_s ? E_W_START : E_NT;
      E_NT:    state_d = E_SAT;
      E_W_START: begin
        if (cnt_s == '0) begin
          miss_go = 1'b1;
          cur_wr  = 1'b1;
          state_d = E_M2_LO;
        end else begin
          rd_addr = {s_idx, start_cur};
          state_d = E_W_CHK0;
        end
      end
      E_W_CHK0: begin
        // frame went backwards: restart at the first segment
        if ((cmd_q.frame < rd_start_q) && (w_cur_q != '0)) begin
          rd_addr = {s_idx, {KW{1'b0}}};
        end else begin
          state_d = E_W_LOOP;
        end
      end
      E_W_LOOP: begin
        if (has_next) begin
          rd_addr = {s_idx, KW'(w_next)};
          state_d = E_W_NXT;
        end else if (found_last) begin
          found_go = 1'b1;
          cur_wr   = 1'b1;
          cur_wd   = w_cur_q;
          state_d  = E_W_LV;
        end else begin
          miss_go = 1'b1;
          cur_wr  = 1'b1;
          state_d = E_M2_LO;
        end
      end
      E_W_NXT: begin
        if (found_nxt) begin
          found_go = 1'b1;
          cur_wr   = 1'b1;
          cur_wd   = w_cur_q;
          state_d  = E_W_LV;
        end else begin
          state_d = E_W_LOOP;
        end
      end
      E_W_LV:   state_d = E_W_P1;
      E_W_P1:   state_d = E_W_P2;
      E_W_P2:   state_d = E_W_P3;
      E_W_P3:   state_d = E_W_P4;
      E_W_P4:   state_d = E_M2_LO;
      E_M2_LO:  state_d = E_M2_HI;
      E_M2_HI:  state_d = E_M2_SUM;
      E_M2_SUM: state_d = E_SAT;
      E_SAT:    state_d = E_DONE;
      E_DONE: begin
        out_push_o = 1'b1;
        state_d    = E_IDLE;
      end
      default: state_d = E_IDLE;
    endcase
    if (found_go) rd_addr = {s_idx, w_cur_q};
  end

  // per-source registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SOURCES; i++) begin
        cnt_q[i] <= '0;
        cur_q[i] <= '0;
        fac_q[i] <= UNITY;
        en_q[i]  <= 1'b0;
      end
    end else begin
      if (src_set) begin
        fac_q[s_idx] <= cmd_q.level;
        cnt_q[s_idx] <= '0;
        cur_q[s_idx] <= '0;
        en_q[s_idx]  <= 1'b0;
      end
      if (cnt_one) cnt_q[s_idx] <= CW'(1);
      if (cnt_inc) cnt_q[s_idx] <= cnt_s + CW'(1);
      if (en_set)  en_q[s_idx]  <= 1'b1;
      if (cur_wr)  cur_q[s_idx] <= cur_wd;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (we_start) start_mem[wr_addr] <= wd_start;
    if (we_lvl)   lvl_mem[wr_addr]   <= wd_lvl;
    if (we_slope) slope_mem[wr_addr] <= wd_slope;
    rd_start_q <= start_mem[rd_addr];
    rd_lvl_q   <= lvl_mem[rd_addr];
    rd_slope_q <= slope_mem[rd_addr];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    logic [78:0] prod, pm;
    logic [40:0] sum, delta;
    logic [63:0] total;
    prod  = {pp_hi_q, 24'd0} + 79'(pp_lo_q);
    pm    = (prod > SAT62) ? SAT62 : prod;
    delta = sneg_q ? 41'(-{2'b00, qmag_q}) : {2'b00, qmag_q};
    sum   = {{17{lvl0_q[23]}}, lvl0_q} + delta;
    total = {m2hi_q, 20'd0} + 64'(m2lo_q);
    if (cmd_pop_o) cmd_q <= cmd_i;
    unique case (state_q)
      E_DISP: begin
        res_smp_q <= '0;
        res_st_q  <= ST_OK;
      end
      E_LAST_RD: begin
        last_q     <= (cnt_s == '0) ? '0 : last_k;
        ls_start_q <= '0;
        ls_lvl_q   <= '0;
      end
      E_LAST_LAT: begin
        ls_start_q <= rd_start_q;
        ls_lvl_q   <= rd_lvl_q;
      end
      E_APP_CMP: begin
        tgt_q <= last_q;
        if ((cmd_q.frame != ls_start_q) && (cnt_s == CW'(MAX_POINTS))) res_st_q <= ST_DROP;
      end
      E_PREV:  tgt_q <= last_q - KW'(1);
      E_CLOSE: tgt_q <= last_q;
      E_AP_M1: begin
        m1_q  <= abs16(cmd_q.sample) * abs24(fac_s);
        neg_q <= cmd_q.sample[15] ^ fac_s[23];
      end
      E_NT:      rmag_q <= 32'(m1_q[39:16]);
      E_W_START: w_cur_q <= start_cur;
      E_W_CHK0: begin
        if ((cmd_q.frame < rd_start_q) && (w_cur_q != '0)) w_cur_q <= '0;
        else x0_q <= rd_start_q;
      end
      E_W_NXT: begin
        if (!found_nxt) begin
          w_cur_q <= w_cur_q + KW'(1);
          x0_q    <= rd_start_q;
        end
      end
      E_W_LV: begin
        lvl0_q <= rd_lvl_q;
        smag_q <= abs48(rd_slope_q);
        sneg_q <= rd_slope_q[47];
      end
      E_W_P1: pp_lo_q <= smag_q[23:0] * d_q;
      E_W_P2: pp_hi_q <= smag_q[47:24] * d_q;
      E_W_P3: qmag_q  <= pm[62:24];
      E_W_P4: begin
        if ($signed(sum) > 41'sd8388607)       env_q <= 24'h7fffff;
        else if ($signed(sum) < -41'sd8388608) env_q <= 24'h800000;
        else                                   env_q <= sum[23:0];
      end
      E_M2_LO: begin
        m2lo_q <= m1_q[19:0] * emag;
        neg_q  <= neg_q ^ env_q[23];
      end
      E_M2_HI:  m2hi_q <= m1_q[39:20] * emag;
      E_M2_SUM: rmag_q <= total[63:32];
      E_SAT: begin
        if (!neg_q) begin
          if (rmag_q > 32'd32767) begin
            res_smp_q <= 16'h7fff;
            res_st_q  <= ST_SAT;
          end else begin
            res_smp_q <= rmag_q[15:0];
          end
        end else begin
          if (rmag_q > 32'd32768) begin
            res_smp_q <= 16'h8000;
            res_st_q  <= ST_SAT;
          end else begin
            res_smp_q <= 16'(-rmag_q[15:0]);
          end
        end
      end
      default: ;
    endcase
    if (found_go) d_q <= cmd_q.frame - x0_q;
    if (miss_go)  env_q <= '0;
  end

  assign out_o.sample = res_smp_q;
  assign out_o.status = res_st_q;

endmodule
`default_nettype wire

>>> rtl/breakpoint_envelope_gain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// breakpoint_envelope_gain
// Per-source gain with piecewise linear breakpoint envelopes.
// ----------------------------------------------------------------------------
// Items enter through a two-beat command queue and results leave through a
// two-beat result queue; one sequencer in the back end works on one item at a
// time. An apply with a table walks the segments, with one breakpoint memory
// read for each segment stepped over, and restarts the walk at the first
// segment when the frame went backwards. An append or close that sets a slope
// waits for the bit-serial 49-bit slope divider.
// Breakpoint memories hold no reset value: entry 0 of a source is written
// when its table is first used.
module breakpoint_envelope_gain #(
  parameter int NUM_SOURCES = 16,
  parameter int MAX_POINTS  = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  mode_i,
  input  wire logic [3:0]  source_i,
  input  wire logic [30:0] frame_index_i,
  input  wire logic [23:0] level_i,
  input  wire logic [15:0] sample_in_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      sample_out_o,
  output logic [1:0]       status_o
);
  import bpeg_pkg::*;

  cmd_t                    cmd;
  res_t                    res_in, res_out;
  logic [$bits(res_t)-1:0] res_raw;
  logic                    cmd_valid, cmd_pop, out_full, out_push;

  bpeg_front #(.NUM_SOURCES(NUM_SOURCES)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .mode_i        (mode_i),
    .source_i      (source_i),
    .frame_index_i (frame_index_i),
    .level_i       (level_i),
    .sample_in_i   (sample_in_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  bpeg_engine #(
    .NUM_SOURCES (NUM_SOURCES),
    .MAX_POINTS  (MAX_POINTS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_o       (res_in)
  );

  // result queue
  bpeg_fifo #(.W($bits(res_t))) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (res_in),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (res_raw),
    .empty_o (empty)
  );

  assign res_out      = res_t'(res_raw);
  assign sample_out_o = res_out.sample;
  assign status_o     = res_out.status;

endmodule
`default_nettype wire

>>> bench/breakpoint_envelope_gain_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// breakpoint_envelope_gain_tb
// Self-checking bench for the breakpoint envelope gain block. An initial block
// queues directed items and random envelope sessions (factor, breakpoints,
// close, applies); a clocked driver pushes them with random gaps and an
// in-bench envelope predictor works out each result, which a clocked monitor
// pops with random stalls and compares field by field.
// ----------------------------------------------------------------------------
module breakpoint_envelope_gain_tb;
  import bpeg_pkg::*;

  localparam int  SOURCES = 16;
  localparam int  POINTS  = 64;
  localparam longint FRAME_END = 64'h7fffffff;
  localparam logic [30:0] FRAME_MAX = 31'h7ffffffe;

  typedef struct {
    mode_e       mode;
    logic [3:0]  src;
    logic [30:0] frame;
    logic [23:0] lvl;
    logic [15:0] smp;
  } gain_beat_t;

  typedef struct {
    logic [15:0] smp;
    status_e     st;
  } gain_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        full, empty;
  logic [15:0] sample_out_o;
  logic [1:0]  status_o;
  gain_beat_t  cur_beat = '{MODE_SET, 4'd0, 31'd0, 24'd0, 16'd0};

  gain_beat_t   pending_beats[$];
  gain_result_t expected_results[$];
  int errors = 0;
  int tx_idle = 0, rx_idle = 0;
  int hold_req = 0, hold_seen = 0, hold_left = 0;

  // Envelope predictor state
  logic [30:0]        bp_frame [SOURCES*POINTS];
  logic signed [23:0] bp_level [SOURCES*POINTS];
  longint             bp_slope [SOURCES*POINTS];
  int                 bp_count [SOURCES];
  int                 walk_seg [SOURCES];
  logic signed [23:0] src_factor [SOURCES];
  bit                 src_closed [SOURCES];

  always #2ns clk_i = ~clk_i;

  breakpoint_envelope_gain u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .mode_i       (cur_beat.mode),
    .source_i     (cur_beat.src),
    .frame_index_i(cur_beat.frame),
    .level_i      (cur_beat.lvl),
    .sample_in_i  (cur_beat.smp),
    .empty        (empty),
    .pop          (pop),
    .sample_out_o (sample_out_o),
    .status_o     (status_o)
  );

  function automatic longint slope_of(longint dy, longint dx);
    longint q;
    if (dx == 0) return 0;
    q = (dy * 64'sd16777216) / dx;
    if (q > (64'sd1 <<< 47) - 1) q = (64'sd1 <<< 47) - 1;
    if (q < -(64'sd1 <<< 47)) q = -(64'sd1 <<< 47);
    return q;
  endfunction

  function automatic void seed_origin(int s);
    if (bp_count[s] == 0) begin
      bp_frame[s*POINTS] = '0;
      bp_level[s*POINTS] = '0;
      bp_slope[s*POINTS] = 0;
      bp_count[s] = 1;
    end
  endfunction

  // Level at a frame, walking segments from the remembered one
  function automatic longint envelope_at(int s, longint f);
    int     b, c, k;
    longint x0, x1, sl, p, v;
    longint unsigned d, mag;
    b = s * POINTS;
    c = bp_count[s];
    k = walk_seg[s];
    if (k >= c) k = 0;
    if (c == 0) begin
      walk_seg[s] = 0;
      return 0;
    end
    if (f < longint'(bp_frame[b+k])) k = 0;
    while (k < c) begin
      x0 = bp_frame[b+k];
      x1 = (k + 1 < c) ? longint'(bp_frame[b+k+1]) : FRAME_END;
      if (f >= x0 && f < x1) break;
      k++;
    end
    if (k >= c) begin
      walk_seg[s] = 0;
      return 0;
    end
    walk_seg[s] = k;
    d = f - longint'(bp_frame[b+k]);
    sl = bp_slope[b+k];
    mag = sl < 0 ? -sl : sl;
    if (d != 0 && mag > (64'd1 << 62) / d) mag = 64'd1 << 62;
    else mag = mag * d;
    p = mag;
    if (sl < 0) p = -p;
    v = longint'(bp_level[b+k]) + p / 64'sd16777216;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v;
  endfunction

  function automatic gain_result_t predict_gain(gain_beat_t bt);
    gain_result_t r;
    int     s, b, c, last;
    longint res;
    s = bt.src;
    b = s * POINTS;
    r.smp = '0;
    r.st = ST_OK;
    res = 0;
    case (bt.mode)
      MODE_SET: begin
        src_factor[s] = bt.lvl;
        bp_count[s] = 0;
        walk_seg[s] = 0;
        src_closed[s] = 0;
      end
      MODE_APPEND: if (!src_closed[s]) begin
        seed_origin(s);
        c = bp_count[s];
        last = b + c - 1;
        if (bt.frame == bp_frame[last]) begin
          // repeated frame replaces the level and repairs the slope before it
          bp_level[last] = bt.lvl;
          if (c >= 2)
            bp_slope[last-1] = slope_of(longint'($signed(bt.lvl)) - bp_level[last-1],
                                        longint'(bt.frame) - bp_frame[last-1]);
        end else if (c >= POINTS) begin
          r.st = ST_DROP;
        end else begin
          bp_slope[last] = slope_of(longint'($signed(bt.lvl)) - bp_level[last],
                                    longint'(bt.frame) - longint'(bp_frame[last]));
          bp_frame[last+1] = bt.frame;
          bp_level[last+1] = bt.lvl;
          bp_slope[last+1] = 0;
          bp_count[s] = c + 1;
        end
      end
      MODE_CLOSE: if (!src_closed[s]) begin
        seed_origin(s);
        last = b + bp_count[s] - 1;
        if (longint'(bp_frame[last]) >= FRAME_END) bp_slope[last] = 0;
        else bp_slope[last] = slope_of(-longint'(bp_level[last]),
                                       FRAME_END - longint'(bp_frame[last]));
        src_closed[s] = 1;
        walk_seg[s] = 0;
      end
      default: begin
        if (src_closed[s])
          res = (longint'($signed(bt.smp)) * longint'(src_factor[s]) *
                 envelope_at(s, longint'(bt.frame))) / (64'sd1 <<< 32);
        else
          res = (longint'($signed(bt.smp)) * longint'(src_factor[s])) / 64'sd65536;
        if (res > 32767) begin
          res = 32767;
          r.st = ST_SAT;
        end else if (res < -32768) begin
          res = -32768;
          r.st = ST_SAT;
        end
        r.smp = res[15:0];
      end
    endcase
    return r;
  endfunction

  // Driver: predict on acceptance, then offer the next pending beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) expected_results.push_back(predict_gain(cur_beat));
      if (!push || !full) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= tx_idle) begin
          push <= 1'b1;
          cur_beat <= pending_beats.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: check popped beats, with random stalls and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result sample %h status %0d", $realtime,
                   sample_out_o, status_o);
          errors++;
        end else begin
          gain_result_t e;
          e = expected_results.pop_front();
          if (sample_out_o !== e.smp) begin
            $display("%0t: sample_out expected %h actual %h", $realtime, e.smp, sample_out_o);
            errors++;
          end
          if (status_o !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $realtime, e.st, status_o);
            errors++;
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= 400;
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  task automatic queue_beat(mode_e m, int s, logic [30:0] f, logic [23:0] l, logic [15:0] x);
    gain_beat_t bt;
    bt.mode = m;
    bt.src = s[3:0];
    bt.frame = f;
    bt.lvl = l;
    bt.smp = x;
    pending_beats.push_back(bt);
  endtask

  function automatic logic [23:0] pick_level();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 24'h20000));
      2: return 24'(-$urandom_range(0, 24'h20000));
      default: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
    endcase
  endfunction

  // One well-formed envelope session on a random source, sometimes broken
  task automatic queue_session(output int added);
    int s, n, k;
    logic [30:0] f;
    s = $urandom_range(SOURCES - 1);
    added = 0;
    queue_beat(MODE_SET, s, 31'($urandom), pick_level(), 16'($urandom));
    n = ($urandom_range(11) == 0) ? 68 : $urandom_range(0, 6);
    f = ($urandom_range(3) == 0) ? 31'd0 : 31'($urandom_range(0, 2000));
    for (k = 0; k < n; k++) begin
      queue_beat(MODE_APPEND, s, f, pick_level(), 16'($urandom));
      case ($urandom_range(9))
        0: ;                                          // repeated frame next
        1: f = 31'($urandom_range(0, 32'h7ffffffe));  // anywhere, maybe backwards
        2: f = (f > FRAME_MAX - 31'h1000000) ? FRAME_MAX : f + 31'($urandom_range(1, 24'hffffff));
        default: f = (f > FRAME_MAX - 31'd5000) ? FRAME_MAX : f + 31'($urandom_range(1, 5000));
      endcase
    end
    added = n + 1;
    if ($urandom_range(9) != 0) begin
      queue_beat(MODE_CLOSE, s, 31'($urandom), 24'($urandom), 16'($urandom));
      added++;
    end
    if ($urandom_range(4) == 0) begin
      queue_beat(MODE_APPEND, s, f, pick_level(), 16'($urandom));
      added++;
    end
    f = 31'($urandom_range(0, 3000));
    for (k = 0; k < $urandom_range(4, 14); k++) begin
      queue_beat(MODE_APPLY, s, f, 24'($urandom), 16'($urandom));
      added++;
      if ($urandom_range(7) == 0) f = 31'($urandom_range(0, 32'h7ffffffe));
      else if (f < FRAME_MAX - 31'd40000) f = f + 31'($urandom_range(0, 40000));
    end
    // noise beats
    for (k = 0; k < $urandom_range(0, 2); k++) begin
      queue_beat(mode_e'($urandom_range(3)), $urandom_range(SOURCES - 1),
                 31'($urandom_range(0, 32'h7ffffffe)), 24'($urandom), 16'($urandom));
      added++;
    end
  endtask

  task automatic run_phase(int items);
    int done, got;
    done = 0;
    while (done < items) begin
      queue_session(got);
      done += got;
      while (pending_beats.size() > 40) @(posedge clk_i);
    end
    while (pending_beats.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    int s;
    for (s = 0; s < SOURCES; s++) begin
      bp_count[s] = 0;
      walk_seg[s] = 0;
      src_factor[s] = UNITY;
      src_closed[s] = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset factor, factor extremes, saturation
    queue_beat(MODE_APPLY, 0, 31'd0, 24'd0, 16'h7fff);
    queue_beat(MODE_SET, 1, 31'd0, 24'h7fffff, 16'd0);
    queue_beat(MODE_APPLY, 1, 31'd5, 24'd0, 16'h7fff);
    queue_beat(MODE_APPLY, 1, 31'd5, 24'd0, 16'h8000);
    queue_beat(MODE_SET, 2, 31'd0, 24'h800000, 16'd0);
    queue_beat(MODE_APPLY, 2, 31'd0, 24'd0, 16'h8000);
    // Envelope with repeated frames, a point at frame zero and a late tail
    queue_beat(MODE_SET, 3, 31'd0, UNITY, 16'd0);
    queue_beat(MODE_APPEND, 3, 31'd0, 24'h008000, 16'd0);
    queue_beat(MODE_APPEND, 3, 31'd100, 24'h7fffff, 16'd0);
    queue_beat(MODE_APPEND, 3, 31'd100, 24'h400000, 16'd0);
    queue_beat(MODE_APPEND, 3, FRAME_MAX, 24'h800000, 16'd0);
    queue_beat(MODE_CLOSE, 3, 31'd0, 24'd0, 16'd0);
    queue_beat(MODE_APPEND, 3, 31'd7, 24'd1, 16'd0);
    queue_beat(MODE_CLOSE, 3, 31'd0, 24'd0, 16'd0);
    queue_beat(MODE_APPLY, 3, 31'd50, 24'd0, 16'h1234);
    queue_beat(MODE_APPLY, 3, FRAME_MAX, 24'd0, 16'h7fff);
    queue_beat(MODE_APPLY, 3, 31'd10, 24'd0, 16'h8000);
    queue_beat(MODE_APPLY, 3, 31'd200, 24'd0, 16'hc000);
    // Breakpoints out of order leave an empty segment; close with no points
    queue_beat(MODE_APPEND, 4, 31'd1000, UNITY, 16'd0);
    queue_beat(MODE_APPEND, 4, 31'd10, 24'h020000, 16'd0);
    queue_beat(MODE_CLOSE, 4, 31'd0, 24'd0, 16'd0);
    queue_beat(MODE_APPLY, 4, 31'd2000, 24'd0, 16'h4000);
    queue_beat(MODE_APPLY, 4, 31'd5, 24'd0, 16'h4000);
    queue_beat(MODE_CLOSE, 5, 31'd0, 24'd0, 16'd0);
    queue_beat(MODE_APPLY, 5, 31'd9, 24'd0, 16'h7fff);

    // Sender pause until the block has drained
    while (pending_beats.size() > 0 || expected_results.size() > 0) @(posedge clk_i);

    tx_idle = 6;
    rx_idle = 83;
    hold_req = 1;
    run_phase(280);
    tx_idle = 83;
    rx_idle = 6;
    run_phase(280);
    tx_idle = 0;
    rx_idle = 0;
    run_phase(290);

    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
